@@ hdl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for clocked checks with a reset disable.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

@@ hdl/cqks_pkg.sv @@
// ============================================================================
// cqks_pkg
// Types and codes of the circular queue with key search.
// ============================================================================
package cqks_pkg;

   localparam int KEY_W        = 56;
   localparam int MODEL_LOW_W  = 64;
   localparam int MODEL_HIGH_W = 16;
   localparam int YEAR_W       = 14;
   localparam int CAP_W        = 4;
   localparam int COUNT_W      = 4;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_SEARCH  = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEQ_DATA,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]        key;
      logic [MODEL_LOW_W-1:0]  model_low;
      logic [MODEL_HIGH_W-1:0] model_high;
      logic [YEAR_W-1:0]       year;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

endpackage

@@ hdl/cqks_ram.sv @@
// ============================================================================
// cqks_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cqks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/circular_queue_with_key_search.sv @@
// ============================================================================
// circular_queue_with_key_search
// Circular FIFO of records (key, payload, year) with enqueue, dequeue and
// search by key; every transaction returns one response with the count.
// ============================================================================
//
//  Channel  Direction  Handshake             Carries
//  req_     in         req_valid/req_stall   action, plate, model, year
//  rsp_     out        rsp_valid/rsp_stall   status, record, count
//  csr_     in         csr_wr_en             capacity (4 bits)
//
//  From accept to response valid: enqueue passes EXEC and FINISH, dequeue
//  EXEC, DEQ_DATA and FINISH, search EXEC, SEARCH once per entry visited
//  (at most count) and FINISH. The record RAM has one read port, so search visits one entry per cycle.
//  One transaction is in flight at a time; req_stall is high from accept
//  until the result moves to the response register, which may still hold
//  an earlier response waiting on rsp_stall.
//  Reset is synchronous: head and count clear, capacity returns to 8, tail
//  to capacity minus one, handshake state clears; the record RAM is not
//  cleared.
//
module circular_queue_with_key_search #(
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [cqks_pkg::KEY_W-1:0]          req_plate,
   input  logic [cqks_pkg::MODEL_LOW_W-1:0]    req_model_low,
   input  logic [cqks_pkg::MODEL_HIGH_W-1:0]   req_model_high,
   input  logic [cqks_pkg::YEAR_W-1:0]         req_year,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [cqks_pkg::KEY_W-1:0]          rsp_plate_out,
   output logic [cqks_pkg::MODEL_LOW_W-1:0]    rsp_model_low_out,
   output logic [cqks_pkg::MODEL_HIGH_W-1:0]   rsp_model_high_out,
   output logic [cqks_pkg::YEAR_W-1:0]         rsp_year_out,
   output logic [cqks_pkg::COUNT_W-1:0]        rsp_count,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [cqks_pkg::CAP_W-1:0]          csr_wr_data
);

   import cqks_pkg::*;

`include "assert_macros.svh"

   localparam int PW         = $clog2(DEPTH);      // slot pointer width
   localparam int CW         = $clog2(DEPTH + 1);  // count width
   localparam int RESET_CAP  = (8 > DEPTH) ? DEPTH : 8;
   localparam logic [PW-1:0] TAIL_RESET = PW'(RESET_CAP - 1);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [PW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]      scan_left_ff, scan_left_in;

   // latched request
   action_type         op_action_ff;
   logic [KEY_W-1:0]   op_key_ff;
   record_type         op_rec_ff;

   // result waiting for the response register
   status_type         res_status_ff, res_status_in;
   record_type         res_rec_ff, res_rec_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   record_type         rsp_rec_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_load;

   // RAM port
   logic               ram_wr_en;
   logic [PW-1:0]      ram_wr_addr;
   logic               ram_rd_en;
   logic [PW-1:0]      ram_rd_addr;
   logic [RECORD_W-1:0] ram_rd_raw;
   record_type         ram_rd_rec;

   logic               req_accept;
   logic [CW-1:0]      eff_cap;

   // slot after ptr, wrapping at the effective capacity
   function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(ptr) + CW'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return PW'(nxt);
   endfunction

   // capacity 0 or beyond the built depth means the whole depth
   always_comb begin
      if (cap_ff == '0 || int'(cap_ff) > DEPTH) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign ram_rd_rec = record_type'(ram_rd_raw);

   // ---------------------------------------------------------------------
   // Record RAM: all four stores side by side in one word
   // ---------------------------------------------------------------------
   cqks_ram #(
      .WIDTH (RECORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (op_rec_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state, pointer updates, RAM accesses
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_left_in  = scan_left_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = advance(tail_ff, eff_cap);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_rec_in    = '0;
            state_in      = ST_FINISH;
            case (op_action_ff)
               ACT_ENQUEUE: begin
                  if (count_ff >= eff_cap) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     tail_in   = ram_wr_addr;
                     count_in  = count_ff + CW'(1);
                  end
               end
               ACT_DEQUEUE: begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     state_in    = ST_DEQ_DATA;
                  end
               end
               ACT_SEARCH: begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = head_ff;
                     scan_ptr_in  = advance(head_ff, eff_cap);
                     scan_left_in = count_ff - CW'(1);
                     state_in     = ST_SEARCH;
                  end
               end
               default: begin
                  // unused action: no queue change, ok status
               end
            endcase
         end

         ST_DEQ_DATA: begin
            res_rec_in = ram_rd_rec;
            head_in    = advance(head_ff, eff_cap);
            count_in   = count_ff - CW'(1);
            state_in   = ST_FINISH;
         end

         ST_SEARCH: begin
            // read data belongs to the entry addressed last cycle
            if (ram_rd_rec.key == op_key_ff) begin
               res_rec_in = ram_rd_rec;
               state_in   = ST_FINISH;
            end else if (scan_left_ff == '0) begin
               res_status_in = STAT_NOT_FOUND;
               state_in      = ST_FINISH;
            end else begin
               ram_rd_en    = 1'b1;
               scan_ptr_in  = advance(scan_ptr_ff, eff_cap);
               scan_left_in = scan_left_ff - CW'(1);
            end
         end

         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register valid: loads from the result, drops on a take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= TAIL_RESET;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(8);
         scan_ptr_ff  <= '0;
         scan_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         scan_ptr_ff  <= scan_ptr_in;
         scan_left_ff <= scan_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_action_ff         <= action_type'(req_action);
         op_key_ff            <= req_plate;
         op_rec_ff.key        <= req_plate;
         op_rec_ff.model_low  <= req_model_low;
         op_rec_ff.model_high <= req_model_high;
         op_rec_ff.year       <= req_year;
      end
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_rec_ff    <= res_rec_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_plate_out      = rsp_rec_ff.key;
   assign rsp_model_low_out  = rsp_rec_ff.model_low;
   assign rsp_model_high_out = rsp_rec_ff.model_high;
   assign rsp_year_out       = rsp_rec_ff.year;
   assign rsp_count          = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_CLK(a_count_in_depth, clock, reset, int'(count_ff) <= DEPTH, "count beyond depth")
   `ASSERT_NEVER(a_write_when_full, clock, reset, ram_wr_en && (count_ff >= eff_cap), "write into a full queue")
   `ASSERT_CLK(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "response without finish")

endmodule

@@ sim/circular_queue_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// circular_queue_checker
// Watches the request, response and capacity ports of the circular queue,
// keeps its own copy of the queue, predicts the response to every accepted
// transaction and compares each accepted response field by field.
// ============================================================================
module circular_queue_checker #(
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [cqks_pkg::KEY_W-1:0]          req_plate,
   input  logic [cqks_pkg::MODEL_LOW_W-1:0]    req_model_low,
   input  logic [cqks_pkg::MODEL_HIGH_W-1:0]   req_model_high,
   input  logic [cqks_pkg::YEAR_W-1:0]         req_year,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_status,
   input  logic [cqks_pkg::KEY_W-1:0]          rsp_plate_out,
   input  logic [cqks_pkg::MODEL_LOW_W-1:0]    rsp_model_low_out,
   input  logic [cqks_pkg::MODEL_HIGH_W-1:0]   rsp_model_high_out,
   input  logic [cqks_pkg::YEAR_W-1:0]         rsp_year_out,
   input  logic [cqks_pkg::COUNT_W-1:0]        rsp_count,
   input  logic                                csr_wr_en,
   input  logic [cqks_pkg::CAP_W-1:0]          csr_wr_data,
   output int                                  error_count,
   output int unsigned                         pending_count
);

   import cqks_pkg::*;

   localparam logic [CAP_W-1:0] RESET_CAPACITY = 4'd8;

   typedef struct packed {
      status_type         status;
      record_type         rec;
      logic [COUNT_W-1:0] fill;
   } response_type;

   record_type       slot_mem [DEPTH];
   int unsigned      head_slot;
   int unsigned      tail_slot;
   int unsigned      fill_level;
   logic [CAP_W-1:0] capacity;
   response_type     expected_responses [$];

   // out-of-range capacity acts as the full depth
   function automatic int unsigned usable_slots();
      if (capacity == 0 || capacity > DEPTH) return DEPTH;
      return int'(capacity);
   endfunction

   function automatic int unsigned next_slot(int unsigned slot);
      return (slot + 1 >= usable_slots()) ? 0 : slot + 1;
   endfunction

   function automatic void predict_queue_op(action_type act, record_type incoming);
      response_type rsp;
      int unsigned  probe;
      bit           hit;
      rsp = '0;
      rsp.status = STAT_OK;
      case (act)
         ACT_ENQUEUE: begin
            if (fill_level >= usable_slots()) begin
               rsp.status = STAT_FULL;
            end else begin
               tail_slot = next_slot(tail_slot);
               slot_mem[tail_slot] = incoming;
               fill_level++;
            end
         end
         ACT_DEQUEUE: begin
            if (fill_level == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               rsp.rec = slot_mem[head_slot];
               head_slot = next_slot(head_slot);
               fill_level--;
            end
         end
         ACT_SEARCH: begin
            if (fill_level == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               // first match walking from head toward tail
               probe = head_slot;
               hit = 1'b0;
               for (int unsigned i = 0; i < fill_level && !hit; i++) begin
                  if (slot_mem[probe].key == incoming.key) begin
                     rsp.rec = slot_mem[probe];
                     hit = 1'b1;
                  end else begin
                     probe = next_slot(probe);
                  end
               end
               if (!hit) rsp.status = STAT_NOT_FOUND;
            end
         end
         default: ;
      endcase
      rsp.fill = fill_level[COUNT_W-1:0];
      expected_responses.push_back(rsp);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         capacity = RESET_CAPACITY;
         head_slot = 0;
         tail_slot = usable_slots() - 1;
         fill_level = 0;
         expected_responses.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unrequested response status", 64'(rsp_status), '0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_plate_out !== want.rec.key)
                  report_mismatch("plate_out", 64'(rsp_plate_out), 64'(want.rec.key));
               if (rsp_model_low_out !== want.rec.model_low)
                  report_mismatch("model_low_out", rsp_model_low_out, want.rec.model_low);
               if (rsp_model_high_out !== want.rec.model_high)
                  report_mismatch("model_high_out", 64'(rsp_model_high_out),
                                  64'(want.rec.model_high));
               if (rsp_year_out !== want.rec.year)
                  report_mismatch("year_out", 64'(rsp_year_out), 64'(want.rec.year));
               if (rsp_count !== want.fill)
                  report_mismatch("count", 64'(rsp_count), 64'(want.fill));
            end
         end
         if (req_valid && !req_stall)
            predict_queue_op(action_type'(req_action),
                             {req_plate, req_model_low, req_model_high, req_year});
      end
      pending_count = expected_responses.size();
   end

endmodule

@@ sim/circular_queue_with_key_search_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// circular_queue_with_key_search_test
// Drives the circular queue with a directed opening, a back-pressure burst
// and phases of random traffic under several capacities and idle patterns;
// a checker beside the block predicts and compares every response.
// ============================================================================
module circular_queue_with_key_search_test;

   import cqks_pkg::*;

   localparam int DEPTH           = 8;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 2;
   // longest transaction is a full search that visits every entry
   localparam int SETTLE_CYCLES   = 16;
   localparam int LONG_HOLD       = 200;
   localparam int PRESSURE_ITEMS  = 30;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int KEY_POOL_SIZE   = 8;
   localparam int YEAR_MAX        = 9999;
   // all ones except the top bit: differs from the all-ones key in one bit
   localparam logic [KEY_W-1:0] KEY_TOP_FLIP = {1'b0, {(KEY_W-1){1'b1}}};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_action;
   logic [KEY_W-1:0]        req_plate;
   logic [MODEL_LOW_W-1:0]  req_model_low;
   logic [MODEL_HIGH_W-1:0] req_model_high;
   logic [YEAR_W-1:0]       req_year;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_status;
   logic [KEY_W-1:0]        rsp_plate_out;
   logic [MODEL_LOW_W-1:0]  rsp_model_low_out;
   logic [MODEL_HIGH_W-1:0] rsp_model_high_out;
   logic [YEAR_W-1:0]       rsp_year_out;
   logic [COUNT_W-1:0]      rsp_count;
   logic                    csr_wr_en;
   logic [CAP_W-1:0]        csr_wr_data;

   int          mismatch_count;
   int unsigned pending_count;

   // idle knobs, percent per cycle; set by the stimulus, read by the drivers
   int unsigned idle_pct     = 0;
   int unsigned stall_pct    = 0;
   bit          hold_pending = 1'b0;

   // keys reused so that searches hit and duplicates land in the queue
   logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
   logic [CAP_W-1:0] cap_plan [NUM_PHASES];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   circular_queue_with_key_search #(.DEPTH(DEPTH)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_plate          (req_plate),
      .req_model_low      (req_model_low),
      .req_model_high     (req_model_high),
      .req_year           (req_year),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_plate_out      (rsp_plate_out),
      .rsp_model_low_out  (rsp_model_low_out),
      .rsp_model_high_out (rsp_model_high_out),
      .rsp_year_out       (rsp_year_out),
      .rsp_count          (rsp_count),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   circular_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_plate          (req_plate),
      .req_model_low      (req_model_low),
      .req_model_high     (req_model_high),
      .req_year           (req_year),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_plate_out      (rsp_plate_out),
      .rsp_model_low_out  (rsp_model_low_out),
      .rsp_model_high_out (rsp_model_high_out),
      .rsp_year_out       (rsp_year_out),
      .rsp_count          (rsp_count),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .error_count        (mismatch_count),
      .pending_count      (pending_count)
   );

   function automatic logic [KEY_W-1:0] random_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 75) return key_pool[$urandom_range(KEY_POOL_SIZE-1)];
      return random_key();
   endfunction

   // One request transaction. Entered and left at a falling edge; valid is
   // left high so back-to-back transactions need no extra assignment.
   task automatic send_request(action_type act, logic [KEY_W-1:0] plate,
                               logic [MODEL_LOW_W-1:0] model_low,
                               logic [MODEL_HIGH_W-1:0] model_high,
                               logic [YEAR_W-1:0] year);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_plate      <= plate;
      req_model_low  <= model_low;
      req_model_high <= model_high;
      req_year       <= year;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // key chosen by the caller, payload random
   task automatic send_keyed(action_type act, logic [KEY_W-1:0] plate);
      send_request(act, plate, {$urandom, $urandom}, MODEL_HIGH_W'($urandom),
                   YEAR_W'($urandom_range(YEAR_MAX)));
   endtask

   // enq_bias: percent of enqueues among enqueue/dequeue picks
   task automatic send_random_item(int unsigned enq_bias);
      int unsigned pick;
      action_type  act;
      pick = $urandom_range(99);
      if (pick < 3)
         act = ACT_NONE;
      else if (pick < 33)
         act = ACT_SEARCH;
      else if ($urandom_range(99) < enq_bias)
         act = ACT_ENQUEUE;
      else
         act = ACT_DEQUEUE;
      // slowly rotate the key pool
      if ($urandom_range(49) == 0) key_pool[$urandom_range(KEY_POOL_SIZE-1)] = random_key();
      send_keyed(act, pick_key());
   endtask

   // Sender pause: stop offering and let every outstanding response arrive,
   // then give the block a few quiet cycles.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: random stalls per cycle, or one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      int waited;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_ENQUEUE;
      req_plate      = '0;
      req_model_low  = '0;
      req_model_high = '0;
      req_year       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = random_key();
      key_pool[0] = '0;
      key_pool[1] = '1;
      cap_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd8, 4'd5, 4'd1};
      cap_plan[NUM_PHASES-1] = CAP_W'($urandom_range(15));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed opening, capacity at its reset value of DEPTH ----
      // empty queue: dequeue and search report empty, unused action is a no-op
      send_keyed(ACT_DEQUEUE, random_key());
      send_keyed(ACT_SEARCH, '0);
      send_keyed(ACT_NONE, random_key());
      // fill every slot; this also makes every stored entry defined before
      // any capacity change can move the pointers onto it
      send_request(ACT_ENQUEUE, '0, '0, '0, '0);
      send_request(ACT_ENQUEUE, '1, '1, '1, YEAR_W'(YEAR_MAX));
      send_keyed(ACT_ENQUEUE, random_key());
      send_keyed(ACT_ENQUEUE, '0);            // duplicate key, older copy must win
      repeat (4) send_keyed(ACT_ENQUEUE, random_key());
      send_keyed(ACT_ENQUEUE, random_key());  // full
      send_keyed(ACT_SEARCH, '0);
      send_keyed(ACT_SEARCH, '1);
      send_keyed(ACT_SEARCH, KEY_TOP_FLIP);   // one key bit off: not found
      send_keyed(ACT_NONE, '1);
      repeat (DEPTH + 1) send_keyed(ACT_DEQUEUE, random_key());  // drain, then empty
      wait_drained();

      // ---- back-pressure: receiver holds off, sender keeps offering ----
      hold_pending = 1'b1;
      repeat (PRESSURE_ITEMS) send_random_item(80);

      // ---- random phases; capacity changes with entries still held ----
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         write_capacity(cap_plan[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_item((ph % 2) ? 35 : 65);
      end

      // ---- wind down ----
      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #(10_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
